// ----- rtl/dfs_pkg.sv -----
`default_nettype none

package dfs_pkg;

  localparam int VIN_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_RESET = 64;
  // candidate bits examined per scan cycle
  localparam int GROUP_W   = 16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FIND  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  typedef struct packed {
    logic accept;
    logic clr;
    logic add_rd_a;
    logic add_wr_a;
    logic add_wr_b;
    logic init;
    logic load;
    logic scan_adv;
    logic push;
    logic pop;
    logic pop_load;
    logic out_rd;
    logic emit_nf;
  } cmd_t;

  typedef struct packed {
    logic a_ok;
    logic b_ok;
    logic same_ab;
    logic grp_any;
    logic grp_last;
    logic next_is_b;
    logic depth_full;
    logic depth_one;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/dfs_ctrl.sv -----
`default_nettype none

module dfs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic [1:0]    opcode_i,
  input  wire dfs_pkg::sts_t sts_i,
  output dfs_pkg::cmd_t      cmd_o,
  output logic               busy
);
  import dfs_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD_RA = 3'd1;
  localparam logic [2:0] ST_ADD_WA = 3'd2;
  localparam logic [2:0] ST_ADD_WB = 3'd3;
  localparam logic [2:0] ST_LOAD   = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_POP    = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0] state_q, state_d;
  opcode_e    op;

  assign op   = opcode_e'(opcode_i);
  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          case (op)
            OP_ADD: begin
              if (sts_i.a_ok && sts_i.b_ok) state_d = ST_ADD_RA;
            end
            OP_FIND: begin
              if (sts_i.a_ok && sts_i.b_ok) begin
                cmd_o.init = 1'b1;
                state_d    = sts_i.same_ab ? ST_OUT : ST_LOAD;
              end else begin
                cmd_o.emit_nf = 1'b1;
              end
            end
            OP_CLEAR: cmd_o.clr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_ADD_RA: begin
        cmd_o.add_rd_a = 1'b1;
        state_d        = ST_ADD_WA;
      end
      ST_ADD_WA: begin
        cmd_o.add_wr_a = 1'b1;
        state_d        = ST_ADD_WB;
      end
      ST_ADD_WB: begin
        cmd_o.add_wr_b = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.grp_any && !sts_i.depth_full) begin
          cmd_o.push = 1'b1;
          state_d    = sts_i.next_is_b ? ST_OUT : ST_LOAD;
        end else if (!sts_i.grp_any && !sts_i.grp_last) begin
          cmd_o.scan_adv = 1'b1;
        end else if (sts_i.depth_one) begin
          // stack runs empty: no path
          cmd_o.emit_nf = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_OUT: begin
        cmd_o.out_rd = 1'b1;
        if (sts_i.depth_one) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dfs_dpath.sv -----
`default_nettype none

module dfs_dpath #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [dfs_pkg::VIN_W-1:0]   vertex_a_i,
  input  wire logic [dfs_pkg::VIN_W-1:0]   vertex_b_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [dfs_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire dfs_pkg::cmd_t               cmd_i,
  output dfs_pkg::sts_t                    sts_o,
  output logic [dfs_pkg::VIN_W-1:0]        path_vertex_o,
  output logic                             found_o,
  output logic                             last_o,
  output logic                             strobe_o
);
  import dfs_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int DW  = $clog2(MAX_VERTICES + 1);
  localparam int CW  = (DW > CFG_W) ? DW : CFG_W;
  localparam int GW  = (MAX_VERTICES < GROUP_W) ? MAX_VERTICES : GROUP_W;
  localparam int NG  = (MAX_VERTICES + GW - 1) / GW;
  localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
  localparam int IW  = $clog2(GW);
  localparam int PW  = NG * GW;

  localparam logic [MAX_VERTICES-1:0] ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  logic [CFG_W-1:0]        cfg_q;
  logic [VW-1:0]           a_q, b_q;
  logic [MAX_VERTICES-1:0] visited_q;
  logic [PW-1:0]           cand_q;
  logic [GIW-1:0]          grp_q;
  logic [DW-1:0]           depth_q;
  logic [DW-1:0]           depth_m1, depth_m2;
  logic [MAX_VERTICES-1:0] row_valid_q;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rdata_q;
  logic                    adj_rvalid_q;
  logic [VW-1:0]           stk_mem [MAX_VERTICES];
  logic [VW-1:0]           stk_rdata_q;

  logic strobe_q, found_q, last_q;

  logic [CW-1:0]           n_eff;
  logic [MAX_VERTICES-1:0] nmask;
  logic [MAX_VERTICES-1:0] row_eff;
  logic [GW-1:0]           grp_bits;
  logic [IW-1:0]           idx;
  logic [VW-1:0]           next_v;
  logic [VW-1:0]           a_in;

  logic                    adj_re, adj_we;
  logic [VW-1:0]           adj_raddr, adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic                    stk_re, stk_we;
  logic [VW-1:0]           stk_raddr, stk_waddr, stk_wdata;

  assign n_eff = (CW'(cfg_q) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(cfg_q);
  assign a_in  = VW'(vertex_a_i);

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = (CW'(i) < n_eff);
    end
  end

  assign row_eff  = adj_rvalid_q ? adj_rdata_q : '0;
  assign grp_bits = cand_q[int'(grp_q)*GW +: GW];

  // lowest set bit of the current group
  always_comb begin
    idx = '0;
    for (int i = GW - 1; i >= 0; i--) begin
      if (grp_bits[i]) idx = IW'(i);
    end
  end

  assign next_v   = VW'(int'(grp_q) * GW + int'(idx));
  assign depth_m1 = depth_q - DW'(1);
  assign depth_m2 = depth_q - DW'(2);

  assign sts_o.a_ok       = (CW'(vertex_a_i) < n_eff);
  assign sts_o.b_ok       = (CW'(vertex_b_i) < n_eff);
  assign sts_o.same_ab    = (vertex_a_i == vertex_b_i);
  assign sts_o.grp_any    = |grp_bits;
  assign sts_o.grp_last   = (grp_q == GIW'(NG - 1));
  assign sts_o.next_is_b  = (next_v == b_q);
  assign sts_o.depth_full = (depth_q == DW'(MAX_VERTICES));
  assign sts_o.depth_one  = (depth_q == DW'(1));

  // adjacency port control
  always_comb begin
    adj_re    = cmd_i.add_rd_a | cmd_i.add_wr_a | cmd_i.init | cmd_i.push | cmd_i.pop_load;
    adj_raddr = a_q;
    if (cmd_i.init)          adj_raddr = a_in;
    else if (cmd_i.push)     adj_raddr = next_v;
    else if (cmd_i.pop_load) adj_raddr = stk_rdata_q;
    else if (cmd_i.add_wr_a) adj_raddr = b_q;
    adj_we    = cmd_i.add_wr_a | cmd_i.add_wr_b;
    adj_waddr = cmd_i.add_wr_a ? a_q : b_q;
    adj_wdata = row_eff | (cmd_i.add_wr_a ? (ONE << b_q) : (ONE << a_q));
  end

  // stack port control
  always_comb begin
    stk_we    = cmd_i.init | cmd_i.push;
    stk_waddr = cmd_i.init ? '0 : depth_q[VW-1:0];
    stk_wdata = cmd_i.init ? a_in : next_v;
    stk_re    = cmd_i.pop | cmd_i.out_rd;
    stk_raddr = cmd_i.pop ? depth_m2[VW-1:0] : depth_m1[VW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_re) adj_rdata_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata_q <= stk_mem[stk_raddr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      a_q <= a_in;
      b_q <= VW'(vertex_b_i);
    end
    if (cmd_i.load) cand_q <= PW'(row_eff & ~visited_q & nmask);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= CFG_W'(CFG_RESET);
      row_valid_q  <= '0;
      adj_rvalid_q <= 1'b0;
      visited_q    <= '0;
      grp_q        <= '0;
      depth_q      <= '0;
      strobe_q     <= 1'b0;
      found_q      <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      // rows not written since the last clear read as empty
      if (cmd_i.clr)   row_valid_q <= '0;
      else if (adj_we) row_valid_q[adj_waddr] <= 1'b1;
      if (adj_re) adj_rvalid_q <= row_valid_q[adj_raddr];

      if (cmd_i.init)      visited_q <= ONE << a_in;
      else if (cmd_i.push) visited_q[next_v] <= 1'b1;

      if (cmd_i.load)          grp_q <= '0;
      else if (cmd_i.scan_adv) grp_q <= grp_q + GIW'(1);

      if (cmd_i.init)                    depth_q <= DW'(1);
      else if (cmd_i.push)               depth_q <= depth_q + DW'(1);
      else if (cmd_i.pop | cmd_i.out_rd) depth_q <= depth_m1;

      strobe_q <= cmd_i.out_rd | cmd_i.emit_nf;
      if (cmd_i.out_rd) begin
        found_q <= 1'b1;
        last_q  <= sts_o.depth_one;
      end else if (cmd_i.emit_nf) begin
        found_q <= 1'b0;
        last_q  <= 1'b1;
      end
    end
  end

  assign strobe_o      = strobe_q;
  assign found_o       = found_q;
  assign last_o        = last_q;
  assign path_vertex_o = found_q ? VIN_W'(stk_rdata_q) : '0;

endmodule

`default_nettype wire

// ----- rtl/dfs_path_finder.sv -----
// Add edge: busy for a read-modify-write of both rows; clear, unused, ignored edge: never busy.
// Find path: a row load after the start and after every push and pop, then a scan of the
// candidates (16 candidate bits per cycle); each pop adds a stack read before its row load.
// Path words stream one per cycle after the end vertex is pushed, each a registered stack read,
// end vertex first; a miss gives one word. Busy drops with the last word; results cannot be stalled.
// Reset is asynchronous: the graph reads empty at once (per-row valid bits), no clearing pass.
`default_nettype none

module dfs_path_finder #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [dfs_pkg::VIN_W-1:0]   vertex_a_i,
  input  wire logic [dfs_pkg::VIN_W-1:0]   vertex_b_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [dfs_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic [dfs_pkg::VIN_W-1:0]        path_vertex_o,
  output logic                             found_o,
  output logic                             last_o,
  output logic                             strobe_o
);
  import dfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  dfs_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vertex_a_i    (vertex_a_i),
    .vertex_b_i    (vertex_b_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .path_vertex_o (path_vertex_o),
    .found_o       (found_o),
    .last_o        (last_o),
    .strobe_o      (strobe_o)
  );

endmodule

`default_nettype wire

// ----- rtl/dfs_checker.sv -----
`default_nettype none

module dfs_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [1:0]                  opcode_i,
  input wire logic [dfs_pkg::VIN_W-1:0]   path_vertex_o,
  input wire logic                        found_o,
  input wire logic                        last_o,
  input wire logic                        strobe_o
);
  import dfs_pkg::*;

  // a miss is a single, final word with a zero vertex
  a_miss_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !found_o |-> last_o && (path_vertex_o == '0))
    else $error("not-found word malformed");

  // path words stream without gaps until the last one
  a_path_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o && found_o)
    else $error("gap inside a path burst");

  // the block stays busy while a path is still streaming
  a_busy_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy)
    else $error("busy dropped during a path burst");

  // edge, clear and unused items produce no word right after acceptance
  a_silent_ops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (opcode_i != OP_FIND) |=> !strobe_o)
    else $error("unexpected word after a non-query item");

endmodule

bind dfs_path_finder dfs_checker u_dfs_checker (.*);

`default_nettype wire

// ----- dv/tb_dfs_path_finder.sv -----
`timescale 1ns / 100ps

module tb_dfs_path_finder;
  import dfs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NV = 64;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]       op;
    logic [VIN_W-1:0] va;
    logic [VIN_W-1:0] vb;
  } graph_cmd_t;

  typedef struct packed {
    logic [VIN_W-1:0] vtx;
    logic             found;
    logic             last;
  } path_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       opcode_i = 2'd0;
  logic [VIN_W-1:0] vertex_a_i = '0;
  logic [VIN_W-1:0] vertex_b_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic [VIN_W-1:0] path_vertex_o;
  logic             found_o;
  logic             last_o;
  logic             strobe_o;

  graph_cmd_t cmd_q[$];
  path_word_t path_words_q[$];

  // graph mirror
  logic [NV-1:0]    adj_rows [NV];
  logic [CFG_W-1:0] vcount_model = CFG_W'(CFG_RESET);

  int posted_cnt = 0;
  int issued_cnt = 0;
  int accepted_cnt = 0;
  int stall_cycles = 0;
  int errors = 0;
  int words_checked = 0;
  int hits = 0;
  int misses = 0;
  bit no_gaps = 1'b0;

  dfs_path_finder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .vertex_a_i   (vertex_a_i),
    .vertex_b_i   (vertex_b_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .path_vertex_o(path_vertex_o),
    .found_o      (found_o),
    .last_o       (last_o),
    .strobe_o     (strobe_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int live_vertices();
    return (vcount_model > NV) ? NV : int'(vcount_model);
  endfunction

  // depth-first walk, lowest neighbour first; path queued end vertex first
  function automatic void predict_path(input logic [VIN_W-1:0] src,
                                       input logic [VIN_W-1:0] dst);
    int n;
    int depth;
    int top;
    int nxt;
    bit hit;
    logic [NV-1:0]    seen;
    logic [VIN_W-1:0] stk [NV];
    path_word_t       w;
    n = live_vertices();
    w = '{vtx: '0, found: 1'b0, last: 1'b1};
    if (src >= n || dst >= n) begin
      path_words_q.push_back(w);
      return;
    end
    seen = '0;
    seen[src] = 1'b1;
    stk[0] = src;
    depth = 1;
    hit = (src == dst);
    while (!hit && depth > 0) begin
      top = stk[depth-1];
      nxt = n;
      for (int i = 0; i < n; i++) begin
        if (i != top && !seen[i] && adj_rows[top][i]) begin
          nxt = i;
          break;
        end
      end
      if (nxt < n && depth < NV) begin
        seen[nxt] = 1'b1;
        stk[depth] = nxt[VIN_W-1:0];
        depth++;
        if (nxt == dst) hit = 1'b1;
      end else begin
        depth--;
      end
    end
    if (!hit) begin
      path_words_q.push_back(w);
      return;
    end
    for (int k = depth; k > 0; k--) begin
      w = '{vtx: stk[k-1], found: 1'b1, last: (k == 1)};
      path_words_q.push_back(w);
    end
  endfunction

  // monitor: check path words, then mirror the accepted command
  always @(posedge clk_i) begin
    path_word_t want;
    bit moved;
    int n;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) begin
        vcount_model = cfg_wdata_i;
        moved = 1'b1;
      end
      if (strobe_o) begin
        moved = 1'b1;
        words_checked++;
        if (path_words_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected path word: vertex %0d found %0b last %0b",
                   $time, path_vertex_o, found_o, last_o);
        end else begin
          want = path_words_q.pop_front();
          if (path_vertex_o !== want.vtx || found_o !== want.found ||
              last_o !== want.last) begin
            errors++;
            $display("%0t: path word mismatch: expected vertex %0d found %0b last %0b,",
                     $time, want.vtx, want.found, want.last);
            $display("%0t:   got vertex %0d found %0b last %0b",
                     $time, path_vertex_o, found_o, last_o);
          end
          if (want.last) begin
            if (want.found) hits++;
            else misses++;
          end
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        accepted_cnt <= accepted_cnt + 1;
        n = live_vertices();
        case (opcode_i)
          OP_ADD: begin
            if (vertex_a_i < n && vertex_b_i < n) begin
              adj_rows[vertex_a_i][vertex_b_i] = 1'b1;
              adj_rows[vertex_b_i][vertex_a_i] = 1'b1;
            end
          end
          OP_FIND: predict_path(vertex_a_i, vertex_b_i);
          OP_CLEAR: begin
            for (int r = 0; r < NV; r++) adj_rows[r] = '0;
          end
          default: ;
        endcase
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  // driver: hold a word until taken, then maybe gap
  always @(negedge clk_i) begin
    graph_cmd_t c;
    if (rst_ni && issued_cnt == accepted_cnt) begin
      if (cmd_q.size() > 0 && (no_gaps || $urandom_range(99) >= 10)) begin
        c = cmd_q.pop_front();
        opcode_i   <= c.op;
        vertex_a_i <= c.va;
        vertex_b_i <= c.vb;
        start      <= 1'b1;
        issued_cnt <= issued_cnt + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    for (int r = 0; r < NV; r++) adj_rows[r] = '0;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  task automatic post_cmd(input logic [1:0] op, input int va, input int vb);
    graph_cmd_t c;
    c = '{op: op, va: va[VIN_W-1:0], vb: vb[VIN_W-1:0]};
    cmd_q.push_back(c);
    posted_cnt++;
  endtask

  function automatic int any_vertex(input int n);
    return (n > 0) ? $urandom_range(n - 1) : $urandom_range(NV - 1);
  endfunction

  // wait until every word is taken and answered, and the block is idle
  task automatic settle();
    while (accepted_cnt != posted_cnt || path_words_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic set_vertex_count(input int v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_phase(input int vc, input int n_items);
    int n;
    int made;
    int pick;
    int len;
    int head;
    int prev;
    int v;
    logic [1:0] op;
    n = (vc > NV) ? NV : vc;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        post_cmd(OP_CLEAR, $urandom_range(63), $urandom_range(63));
        made++;
      end else if (pick < 14) begin
        op = 2'($urandom_range(3));
        post_cmd(op, $urandom_range(63), $urandom_range(63));
        if (op != OP_UNUSED) made++;
      end else if (pick < 32 && n > 1) begin
        // chain of edges, then search between its ends
        len = $urandom_range(2, 8);
        head = any_vertex(n);
        prev = head;
        repeat (len) begin
          v = any_vertex(n);
          post_cmd(OP_ADD, prev, v);
          prev = v;
          made++;
        end
        if ($urandom_range(1)) post_cmd(OP_FIND, head, prev);
        else post_cmd(OP_FIND, prev, head);
        made++;
      end else if (pick < 62) begin
        post_cmd(OP_ADD, any_vertex(n), any_vertex(n));
        made++;
      end else begin
        if ($urandom_range(99) < 85) post_cmd(OP_FIND, any_vertex(n), any_vertex(n));
        else post_cmd(OP_FIND, $urandom_range(63), $urandom_range(63));
        made++;
      end
    end
  endtask

  initial begin
    logic [VIN_W-1:0] perm [NV];
    logic [VIN_W-1:0] tmp;
    int j;
    int vc_plan [10];
    int len_plan [10];

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset count: self path, empty graph, chains, self loop, unused opcode, clear
    post_cmd(OP_FIND, 0, 0);
    post_cmd(OP_FIND, 0, 63);
    post_cmd(OP_ADD, 0, 63);
    post_cmd(OP_FIND, 63, 0);
    post_cmd(OP_ADD, 0, 1);
    post_cmd(OP_ADD, 1, 2);
    post_cmd(OP_ADD, 2, 62);
    post_cmd(OP_FIND, 62, 63);
    post_cmd(OP_ADD, 7, 7);
    post_cmd(OP_FIND, 7, 8);
    post_cmd(OP_UNUSED, 63, 63);
    post_cmd(OP_CLEAR, 0, 0);
    post_cmd(OP_FIND, 0, 63);
    post_cmd(OP_ADD, 63, 62);
    post_cmd(OP_FIND, 62, 63);
    // zero vertices: everything out of range
    set_vertex_count(0);
    post_cmd(OP_ADD, 1, 2);
    post_cmd(OP_FIND, 0, 0);
    // above the maximum acts as the maximum
    set_vertex_count(127);
    post_cmd(OP_FIND, 1, 2);
    post_cmd(OP_FIND, 63, 62);
    post_cmd(OP_FIND, 63, 63);
    set_vertex_count(1);
    post_cmd(OP_FIND, 0, 0);
    post_cmd(OP_FIND, 0, 1);
    post_cmd(OP_ADD, 0, 1);
    set_vertex_count(2);
    post_cmd(OP_ADD, 0, 1);
    post_cmd(OP_FIND, 1, 0);

    // one path through all vertices, shuffled order
    set_vertex_count(64);
    for (int i = 0; i < NV; i++) perm[i] = i[VIN_W-1:0];
    for (int i = NV - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    post_cmd(OP_CLEAR, 0, 0);
    for (int i = 0; i < NV - 1; i++) post_cmd(OP_ADD, perm[i], perm[i+1]);
    post_cmd(OP_FIND, perm[0], perm[NV-1]);
    post_cmd(OP_FIND, perm[NV-1], perm[0]);
    post_cmd(OP_FIND, perm[NV/2], perm[0]);

    vc_plan  = '{64, 2, 9, 33, 64, 127, 1, 0, 65, 0};
    len_plan = '{50, 40, 50, 50, 50, 40, 15, 15, 30, 40};
    vc_plan[9] = $urandom_range(3, 64);
    for (int p = 0; p < 10; p++) begin
      set_vertex_count(vc_plan[p]);
      no_gaps = (p == 4);
      random_phase(vc_plan[p], len_plan[p]);
    end

    settle();
    repeat (40) @(negedge clk_i);
    if (path_words_q.size() != 0) begin
      errors++;
      $display("%0t: %0d path words never arrived", $time, path_words_q.size());
    end
    $display("summary: %0d commands taken, %0d path words checked,",
             accepted_cnt, words_checked);
    $display("summary: %0d searches hit, %0d missed", hits, misses);
    $display("summary: vertex counts 0 to 127 incl. a full 64-vertex chain, %0d mismatches",
             errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
